/* src/xcr_pkg.sv */
package xcr_pkg;

    // Framing characters
    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_CAN  = 8'h18;
    localparam logic [7:0] CH_POLL = 8'h43;

    // Request kinds on the input channel
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Final status codes
    localparam logic [1:0] ST_SUCCESS   = 2'd0;
    localparam logic [1:0] ST_BLK_FAIL  = 2'd1;
    localparam logic [1:0] ST_CANCELLED = 2'd2;
    localparam logic [1:0] ST_1K_BLOCK  = 2'd3;

    // Error flag bits
    localparam logic [2:0] FL_COMP = 3'b001;
    localparam logic [2:0] FL_SEQ  = 3'b010;
    localparam logic [2:0] FL_CRC  = 3'b100;

    // Field widths
    localparam int IDX_W = 7;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        PH_WAIT_FIRST = 3'd0,
        PH_CMD        = 3'd1,
        PH_BLKNUM     = 3'd2,
        PH_BLKCOMP    = 3'd3,
        PH_DATA       = 3'd4,
        PH_CRCHI      = 3'd5,
        PH_CRCLO      = 3'd6,
        PH_DONE       = 3'd7
    } t_phase;

    // CRC-16, MSB first, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* src/xmodem_crc_receiver_unit.sv */
// XMODEM-CRC receiver for 128-byte blocks. Each input request is either a
// byte from the sender (tuser 0) or a poll tick (tuser 1); polls make the
// block answer 'C' only until the first command arrives. Data bytes of each
// block stream out as they arrive, with their index in the block; after the
// CRC low byte the block answers ACK, or CAN with error flags and ends the
// transfer. EOT, CAN or STX as a command end the transfer; once ended, all
// requests are swallowed until reset. Header and CRC high bytes give no result.
// Throughput is one request per clock while the output is not stalled: the
// request lands in an input register, and the framing update together with
// a byte-wide CRC-16 step then fills the result register.
module xmodem_crc_receiver_unit #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte, [15:8] payload_byte, [22:16] payload_index,
    // [24:23] status, [27:25] error_flags, [31:28] zero
    output logic [31:0] m_axis_tdata,
    // [0] tx_valid, [1] payload_valid, [2] done_res
    output logic [2:0]  m_axis_tuser
);

    localparam int POS_W = $clog2(BLOCK_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_BYTES - 1);

    // Input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // Framing state
    xcr_pkg::t_phase   r_phase, n_phase;
    logic [7:0]        r_expected, n_expected;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_blk_seen, n_blk_seen;
    logic [7:0]        r_crc_hi, n_crc_hi;
    logic [2:0]        r_fault, n_fault;

    // Result register
    logic                     r_out_valid;
    logic                     r_tx_valid, r_pay_valid, r_done;
    logic [7:0]               r_tx_byte, r_pay_byte;
    logic [xcr_pkg::IDX_W-1:0] r_pay_idx;
    logic [1:0]               r_status;
    logic [2:0]               r_flags;

    // Result of the current step
    logic                     res_valid;
    logic                     res_tx_valid, res_pay_valid, res_done;
    logic [7:0]               res_tx_byte, res_pay_byte;
    logic [xcr_pkg::IDX_W-1:0] res_pay_idx;
    logic [1:0]               res_status;
    logic [2:0]               res_flags;

    logic out_free;
    logic step;
    logic [15:0] crc_next;
    logic [2:0]  flags_lo;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    assign crc_next = xcr_pkg::crc_byte(r_crc, r_in_byte);
    assign flags_lo = r_fault | (({r_crc_hi, r_in_byte} != r_crc) ? xcr_pkg::FL_CRC : 3'b000);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_expected = r_expected;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_blk_seen = r_blk_seen;
        n_crc_hi   = r_crc_hi;
        n_fault    = r_fault;
        if (r_in_op == xcr_pkg::OP_BYTE) begin
            case (r_phase)
                xcr_pkg::PH_WAIT_FIRST, xcr_pkg::PH_CMD: begin
                    if (r_in_byte == xcr_pkg::CH_SOH) begin
                        n_phase = xcr_pkg::PH_BLKNUM;
                        n_pos   = '0;
                        n_crc   = '0;
                        n_fault = '0;
                    end else if (r_in_byte == xcr_pkg::CH_EOT || r_in_byte == xcr_pkg::CH_CAN
                                 || r_in_byte == xcr_pkg::CH_STX) begin
                        n_phase = xcr_pkg::PH_DONE;
                    end
                end
                xcr_pkg::PH_BLKNUM: begin
                    n_blk_seen = r_in_byte;
                    n_phase    = xcr_pkg::PH_BLKCOMP;
                end
                xcr_pkg::PH_BLKCOMP: begin
                    if (r_blk_seen != ~r_in_byte) begin
                        n_fault = n_fault | xcr_pkg::FL_COMP;
                    end
                    if (r_blk_seen != r_expected) begin
                        n_fault = n_fault | xcr_pkg::FL_SEQ;
                    end
                    n_pos   = '0;
                    n_phase = xcr_pkg::PH_DATA;
                end
                xcr_pkg::PH_DATA: begin
                    n_crc = crc_next;
                    n_pos = r_pos + 1'b1;
                    if (r_pos == POS_LAST) begin
                        n_phase = xcr_pkg::PH_CRCHI;
                    end
                end
                xcr_pkg::PH_CRCHI: begin
                    n_crc_hi = r_in_byte;
                    n_phase  = xcr_pkg::PH_CRCLO;
                end
                xcr_pkg::PH_CRCLO: begin
                    n_fault = flags_lo;
                    if (flags_lo != 3'b000) begin
                        n_phase = xcr_pkg::PH_DONE;
                    end else begin
                        n_expected = r_expected + 8'd1;
                        n_phase    = xcr_pkg::PH_CMD;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Step outputs
    always_comb begin
        res_valid     = 1'b0;
        res_tx_valid  = 1'b0;
        res_tx_byte   = 8'h00;
        res_pay_valid = 1'b0;
        res_pay_byte  = 8'h00;
        res_pay_idx   = '0;
        res_done      = 1'b0;
        res_status    = xcr_pkg::ST_SUCCESS;
        res_flags     = 3'b000;
        if (r_in_op == xcr_pkg::OP_POLL) begin
            if (r_phase == xcr_pkg::PH_WAIT_FIRST) begin
                res_valid    = 1'b1;
                res_tx_valid = 1'b1;
                res_tx_byte  = xcr_pkg::CH_POLL;
            end
        end else begin
            case (r_phase)
                xcr_pkg::PH_WAIT_FIRST, xcr_pkg::PH_CMD: begin
                    if (r_in_byte == xcr_pkg::CH_EOT) begin
                        res_valid    = 1'b1;
                        res_tx_valid = 1'b1;
                        res_tx_byte  = xcr_pkg::CH_ACK;
                        res_done     = 1'b1;
                        res_status   = xcr_pkg::ST_SUCCESS;
                    end else if (r_in_byte == xcr_pkg::CH_CAN) begin
                        res_valid  = 1'b1;
                        res_done   = 1'b1;
                        res_status = xcr_pkg::ST_CANCELLED;
                    end else if (r_in_byte == xcr_pkg::CH_STX) begin
                        res_valid  = 1'b1;
                        res_done   = 1'b1;
                        res_status = xcr_pkg::ST_1K_BLOCK;
                    end
                end
                xcr_pkg::PH_DATA: begin
                    res_valid     = 1'b1;
                    res_pay_valid = 1'b1;
                    res_pay_byte  = r_in_byte;
                    res_pay_idx   = r_pos[xcr_pkg::IDX_W-1:0];
                end
                xcr_pkg::PH_CRCLO: begin
                    res_valid    = 1'b1;
                    res_tx_valid = 1'b1;
                    if (flags_lo != 3'b000) begin
                        res_tx_byte = xcr_pkg::CH_CAN;
                        res_done    = 1'b1;
                        res_status  = xcr_pkg::ST_BLK_FAIL;
                        res_flags   = flags_lo;
                    end else begin
                        res_tx_byte = xcr_pkg::CH_ACK;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // State registers, advanced once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= xcr_pkg::PH_WAIT_FIRST;
            r_expected <= 8'd1;
            r_pos      <= '0;
            r_crc      <= '0;
            r_blk_seen <= '0;
            r_crc_hi   <= '0;
            r_fault    <= '0;
        end else if (step && r_phase != xcr_pkg::PH_DONE) begin
            r_phase    <= n_phase;
            r_expected <= n_expected;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_blk_seen <= n_blk_seen;
            r_crc_hi   <= n_crc_hi;
            r_fault    <= n_fault;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid && (r_phase != xcr_pkg::PH_DONE);
        end
        if (out_free) begin
            r_tx_valid  <= res_tx_valid;
            r_tx_byte   <= res_tx_byte;
            r_pay_valid <= res_pay_valid;
            r_pay_byte  <= res_pay_byte;
            r_pay_idx   <= res_pay_idx;
            r_done      <= res_done;
            r_status    <= res_status;
            r_flags     <= res_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_flags, r_status, r_pay_idx, r_pay_byte, r_tx_byte};
    assign m_axis_tuser  = {r_done, r_pay_valid, r_tx_valid};

endmodule
